// ===== rtl/tli_pkg.sv =====
// shared types and constants of the table linear interpolator
// no dependencies; used by every rtl file of the block but tli_ram
`default_nettype none

package tli_pkg;

   localparam int DATA_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int DIV_CNT_W  = $clog2(FRAC_W + 1);
   localparam int PROD_W     = DATA_W + FRAC_W + 2;
   localparam int OPCODE_W   = 2;
   localparam int ROW_IDX_W  = 8;
   localparam int COL_IDX_W  = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int POINTS_W   = 9;
   localparam int COLUMNS_W  = 3;

   localparam logic [OPCODE_W-1:0] OP_WR_BREAKPOINT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_WR_SAMPLE     = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY         = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_POINTS_IN_USE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS_IN_USE = 2'd1;

   localparam logic [POINTS_W-1:0]  POINTS_RESET  = 9'd256;
   localparam logic [COLUMNS_W-1:0] COLUMNS_RESET = 3'd1;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] num;
      logic [DATA_W-1:0] den;
   } div_req_type;

endpackage

`default_nettype wire

// ===== rtl/tli_if.sv =====
// channel interfaces of the table linear interpolator
// depends on tli_pkg
`default_nettype none

interface tli_req_if;
   logic                                  valid;
   logic                                  ready;
   logic        [tli_pkg::OPCODE_W-1:0]  opcode;
   logic        [tli_pkg::ROW_IDX_W-1:0] point_index;
   logic        [tli_pkg::COL_IDX_W-1:0] column_index;
   logic signed [tli_pkg::DATA_W-1:0]    value;

   modport source (output valid, opcode, point_index, column_index, value, input ready);
   modport sink (input valid, opcode, point_index, column_index, value, output ready);
endinterface

interface tli_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [tli_pkg::DATA_W-1:0]    result_value;
   logic        [tli_pkg::COL_IDX_W-1:0] result_column;
   logic                                  last_column;

   modport source (output valid, result_value, result_column, last_column, input ready);
   modport sink (input valid, result_value, result_column, last_column, output ready);
endinterface

interface tli_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [tli_pkg::CSR_IDX_W-1:0]         index;
   logic [tli_pkg::CSR_DATA_W-1:0]        data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tli_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module tli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/tli_div.sv =====
// restoring divider giving the fraction bits of num / den, one bit per cycle
// requires num < den; depends on tli_pkg
`default_nettype none

module tli_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tli_pkg::div_req_type        req,
   output      logic                        busy,
   output      logic [tli_pkg::FRAC_W-1:0]  quot
);

   logic                           busy_ff, busy_in;
   logic [tli_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [tli_pkg::DATA_W-1:0]     rem_ff, rem_in;
   logic [tli_pkg::DATA_W-1:0]     den_ff, den_in;
   logic [tli_pkg::FRAC_W-1:0]     quot_ff, quot_in;
   logic [tli_pkg::DATA_W:0]       shifted;
   logic [tli_pkg::DATA_W:0]       trial;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      trial   = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = tli_pkg::DIV_CNT_W'(tli_pkg::FRAC_W);
         rem_in  = req.num;
         den_in  = req.den;
      end else if (busy_ff) begin
         if (!trial[tli_pkg::DATA_W]) begin
            rem_in  = trial[tli_pkg::DATA_W-1:0];
            quot_in = {quot_ff[tli_pkg::FRAC_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[tli_pkg::DATA_W-1:0];
            quot_in = {quot_ff[tli_pkg::FRAC_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - tli_pkg::DIV_CNT_W'(1);
         busy_in = (cnt_ff != tli_pkg::DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

// ===== rtl/table_linear_interpolator.sv =====
// table linear interpolator top level; depends on tli_pkg, tli_if, tli_ram, tli_div
// writes leave the input ready; a query at or outside the end breakpoints reads one sample per
// column; one inside walks the breakpoints on the one read port (at most points_in_use - 2
// passed), waits for the divider, then per column reads two samples, multiplies and adds; a
// stalled result holds the add; one item at a time, the last result may wait while the next is
// taken; reset clears control and csr state, table contents stay undefined until written
`default_nettype none

module table_linear_interpolator #(
   parameter int MAX_POINTS  = 256,
   parameter int MAX_COLUMNS = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   tli_req_if.sink   req_bus,
   tli_rsp_if.source rsp_bus,
   tli_csr_if.sink   csr_bus
);

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int CLW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int SDEPTH = MAX_POINTS * (2 ** CLW);
   localparam int PCW   = ($clog2(MAX_POINTS + 1) > tli_pkg::POINTS_W) ?
                          $clog2(MAX_POINTS + 1) : tli_pkg::POINTS_W;
   localparam int CCW   = ($clog2(MAX_COLUMNS + 1) > tli_pkg::COLUMNS_W) ?
                          $clog2(MAX_COLUMNS + 1) : tli_pkg::COLUMNS_W;
   localparam int DW    = tli_pkg::DATA_W;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_FIRST = 4'd1;
   localparam logic [3:0] ST_LAST  = 4'd2;
   localparam logic [3:0] ST_SRCH  = 4'd3;
   localparam logic [3:0] ST_DIV   = 4'd4;
   localparam logic [3:0] ST_RDL   = 4'd5;
   localparam logic [3:0] ST_RDH   = 4'd6;
   localparam logic [3:0] ST_MUL   = 4'd7;
   localparam logic [3:0] ST_ADD   = 4'd8;

   logic [3:0]                      state_ff, state_in;
   logic [tli_pkg::POINTS_W-1:0]    points_ff, points_in;
   logic [tli_pkg::COLUMNS_W-1:0]   columns_ff, columns_in;
   logic signed [DW-1:0]            x_ff, x_in;
   logic signed [DW-1:0]            xl_ff, xl_in;
   logic [AW-1:0]                   hi_ff, hi_in;
   logic [AW-1:0]                   lo_ff, lo_in;
   logic [AW-1:0]                   nm1_ff, nm1_in;
   logic [CLW-1:0]                  ncm1_ff, ncm1_in;
   logic [CLW-1:0]                  col_ff, col_in;
   logic                            edge_ff, edge_in;
   logic signed [DW-1:0]            yl_ff, yl_in;
   logic signed [tli_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]                   rsp_value_ff, rsp_value_in;
   logic [tli_pkg::COL_IDX_W-1:0]   rsp_col_ff, rsp_col_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic                            req_beat;
   logic                            out_free;
   logic [PCW-1:0]                  pts_ext;
   logic [CCW-1:0]                  cols_ext;
   logic                            bp_wr_en;
   logic                            smp_wr_en;
   logic [AW-1:0]                   bp_rd_addr;
   logic [AW+CLW-1:0]               smp_rd_addr;
   logic [DW-1:0]                   bp_rd_data;
   logic [DW-1:0]                   smp_rd_data;
   logic signed [DW-1:0]            bp_data;
   logic signed [DW-1:0]            smp_data;
   logic signed [DW:0]              y_diff;
   tli_pkg::div_req_type            div_req;
   logic                            div_busy;
   logic [tli_pkg::FRAC_W-1:0]      div_quot;

   assign req_beat  = req_bus.valid && req_bus.ready;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign pts_ext   = PCW'(points_ff);
   assign cols_ext  = CCW'(columns_ff);
   assign bp_data   = $signed(bp_rd_data);
   assign smp_data  = $signed(smp_rd_data);
   assign y_diff    = {smp_data[DW-1], smp_data} - {yl_ff[DW-1], yl_ff};

   assign bp_wr_en  = req_beat && (req_bus.opcode == tli_pkg::OP_WR_BREAKPOINT)
                      && (32'(req_bus.point_index) < MAX_POINTS);
   assign smp_wr_en = req_beat && (req_bus.opcode == tli_pkg::OP_WR_SAMPLE)
                      && (32'(req_bus.point_index) < MAX_POINTS)
                      && (32'(req_bus.column_index) < MAX_COLUMNS);

   // breakpoint read address: one read issued each cycle for the next compare
   always_comb begin
      case (state_ff)
         ST_FIRST: bp_rd_addr = nm1_ff;
         ST_LAST:  bp_rd_addr = AW'(1);
         ST_SRCH:  bp_rd_addr = hi_ff + AW'(1);
         default:  bp_rd_addr = '0;
      endcase
   end

   assign smp_rd_addr = (state_ff == ST_RDL) ? {lo_ff, col_ff} : {hi_ff, col_ff};

   tli_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_bp_ram (
      .clock   (clock),
      .wr_en   (bp_wr_en),
      .wr_addr (AW'(req_bus.point_index)),
      .wr_data (req_bus.value),
      .rd_addr (bp_rd_addr),
      .rd_data (bp_rd_data)
   );

   tli_ram #(.WIDTH(DW), .DEPTH(SDEPTH)) u_smp_ram (
      .clock   (clock),
      .wr_en   (smp_wr_en),
      .wr_addr ({AW'(req_bus.point_index), CLW'(req_bus.column_index)}),
      .wr_data (req_bus.value),
      .rd_addr (smp_rd_addr),
      .rd_data (smp_rd_data)
   );

   tli_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      points_in    = points_ff;
      columns_in   = columns_ff;
      x_in         = x_ff;
      xl_in        = xl_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      nm1_in       = nm1_ff;
      ncm1_in      = ncm1_ff;
      col_in       = col_ff;
      edge_in      = edge_ff;
      yl_in        = yl_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in = rsp_value_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      div_req.start = 1'b0;
      div_req.num   = DW'(x_ff - xl_ff);
      div_req.den   = DW'(bp_data - xl_ff);

      if (csr_bus.valid) begin
         case (csr_bus.index)
            tli_pkg::CSR_POINTS_IN_USE:  points_in  = csr_bus.data;
            tli_pkg::CSR_COLUMNS_IN_USE: columns_in = csr_bus.data[tli_pkg::COLUMNS_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_beat && (req_bus.opcode == tli_pkg::OP_QUERY)) begin
               x_in   = req_bus.value;
               col_in = '0;
               if (pts_ext == '0) begin
                  nm1_in = '0;
               end else if (pts_ext > PCW'(MAX_POINTS)) begin
                  nm1_in = AW'(MAX_POINTS - 1);
               end else begin
                  nm1_in = AW'(pts_ext - PCW'(1));
               end
               if (cols_ext == '0) begin
                  ncm1_in = '0;
               end else if (cols_ext > CCW'(MAX_COLUMNS)) begin
                  ncm1_in = CLW'(MAX_COLUMNS - 1);
               end else begin
                  ncm1_in = CLW'(cols_ext - CCW'(1));
               end
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (x_ff <= bp_data) begin
               edge_in  = 1'b1;
               lo_in    = '0;
               state_in = ST_RDL;
            end else begin
               xl_in    = bp_data;
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            if (x_ff >= bp_data) begin
               edge_in  = 1'b1;
               lo_in    = nm1_ff;
               state_in = ST_RDL;
            end else begin
               hi_in    = AW'(1);
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            if ((hi_ff < nm1_ff) && (bp_data <= x_ff)) begin
               xl_in = bp_data;
               hi_in = hi_ff + AW'(1);
            end else begin
               div_req.start = 1'b1;
               edge_in       = 1'b0;
               lo_in         = hi_ff - AW'(1);
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!div_busy) begin
               state_in = ST_RDL;
            end
         end
         ST_RDL: begin
            state_in = ST_RDH;
         end
         ST_RDH: begin
            yl_in = smp_data;
            if (edge_ff) begin
               prod_in  = '0;
               state_in = ST_ADD;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = y_diff * $signed({1'b0, div_quot});
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = DW'(yl_ff) + prod_ff[tli_pkg::FRAC_W +: DW];
               rsp_col_in   = tli_pkg::COL_IDX_W'(col_ff);
               rsp_last_in  = (col_ff == ncm1_ff);
               if (col_ff == ncm1_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in   = col_ff + CLW'(1);
                  state_in = ST_RDL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         points_ff    <= tli_pkg::POINTS_RESET;
         columns_ff   <= tli_pkg::COLUMNS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         points_ff    <= points_in;
         columns_ff   <= columns_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff         <= x_in;
      xl_ff        <= xl_in;
      hi_ff        <= hi_in;
      lo_ff        <= lo_in;
      nm1_ff       <= nm1_in;
      ncm1_ff      <= ncm1_in;
      col_ff       <= col_in;
      edge_ff      <= edge_in;
      yl_ff        <= yl_in;
      prod_ff      <= prod_in;
      rsp_value_ff <= rsp_value_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign csr_bus.ready         = 1'b1;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.result_value  = $signed(rsp_value_ff);
   assign rsp_bus.result_column = rsp_col_ff;
   assign rsp_bus.last_column   = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/tli_chk.sv =====
// port-level checks of the table linear interpolator, bound to the top level
// depends on tli_pkg and tli_if
`default_nettype none

module tli_chk (
   input wire logic  clock,
   input wire logic  reset,
   tli_req_if.sink   req_bus,
   tli_rsp_if.source rsp_bus,
   tli_csr_if.sink   csr_bus
);

   // stalled beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid && $stable(rsp_bus.result_value)
         && $stable(rsp_bus.result_column) && $stable(rsp_bus.last_column))
      else $error("rsp beat changed while stalled");

   // a query keeps the input side closed while it is worked on
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready && (req_bus.opcode == tli_pkg::OP_QUERY)
         |=> !req_bus.ready)
      else $error("input ready right after a query");

   // a table write or an ignored item leaves the input ready in the next cycle
   a_write_quick: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready && (req_bus.opcode != tli_pkg::OP_QUERY)
         |=> req_bus.ready)
      else $error("input not ready after a write");

   // columns still owed while a non-final beat is shown
   a_cols_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.last_column |-> !req_bus.ready)
      else $error("input ready before last column");

   // configuration is always taken
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_bus.valid |-> csr_bus.ready)
      else $error("csr beat stalled");

endmodule

bind table_linear_interpolator tli_chk u_tli_chk (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus),
   .csr_bus (csr_bus)
);

`default_nettype wire

// ===== tb/tli_checker.sv =====
`timescale 1ns / 100ps
// scoreboard of the table linear interpolator: mirrors the tables and registers from
// observed beats, predicts each column result of a query and compares it in order
// depends on tli_pkg and tli_if
module tli_checker #(
   parameter int MAX_POINTS  = 256,
   parameter int MAX_COLUMNS = 4
) (
   input  logic clock,
   input  logic reset,
   tli_req_if   req_bus,
   tli_rsp_if   rsp_bus,
   tli_csr_if   csr_bus,
   output int   fail_count,
   output int   outstanding,
   output int   results_checked
);
   import tli_pkg::*;

   typedef struct {
      logic signed [DATA_W-1:0]    value;
      logic        [COL_IDX_W-1:0] column;
      logic                        last;
   } column_result_type;

   logic signed [DATA_W-1:0] knot_table [MAX_POINTS];
   logic signed [DATA_W-1:0] sample_table [MAX_POINTS][MAX_COLUMNS];
   logic [POINTS_W-1:0]      points_reg;
   logic [COLUMNS_W-1:0]     columns_reg;
   column_result_type        expected_columns [$];
   column_result_type        want;
   int                       mismatches;
   int                       checked;

   initial begin
      fail_count      = 0;
      outstanding     = 0;
      results_checked = 0;
      mismatches      = 0;
      checked         = 0;
      points_reg      = POINTS_RESET;
      columns_reg     = COLUMNS_RESET;
   end

   function automatic void interpolate_query(input logic signed [DATA_W-1:0] x);
      int                n;
      int                nc;
      int                hi;
      int                row;
      logic              interior;
      longint            xl;
      longint            xh;
      longint            yl;
      longint            yh;
      longint            frac;
      longint            r;
      column_result_type item;
      n = int'(points_reg);
      if (n < 1) n = 1;
      if (n > MAX_POINTS) n = MAX_POINTS;
      nc = int'(columns_reg);
      if (nc < 1) nc = 1;
      if (nc > MAX_COLUMNS) nc = MAX_COLUMNS;
      hi       = 1;
      row      = 0;
      interior = 1'b0;
      frac     = 0;
      if (x <= knot_table[0]) begin
         row = 0;
      end else if (x >= knot_table[n-1]) begin
         row = n - 1;
      end else begin
         interior = 1'b1;
         while (hi < n - 1 && knot_table[hi] <= x) hi++;
         xh   = knot_table[hi];
         xl   = knot_table[hi-1];
         frac = ((longint'(x) - xl) <<< FRAC_W) / (xh - xl);
      end
      for (int c = 0; c < nc; c++) begin
         if (interior) begin
            yl = sample_table[hi-1][c];
            yh = sample_table[hi][c];
            r  = yl + (((yh - yl) * frac) >>> FRAC_W);
         end else begin
            r = sample_table[row][c];
         end
         item.value  = r[DATA_W-1:0];
         item.column = c[COL_IDX_W-1:0];
         item.last   = (c == nc - 1);
         expected_columns.push_back(item);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         points_reg  = POINTS_RESET;
         columns_reg = COLUMNS_RESET;
         expected_columns.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            checked++;
            if (expected_columns.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat: value %h column %0d last %0b",
                           rsp_bus.result_value, rsp_bus.result_column, rsp_bus.last_column);
            end else begin
               want = expected_columns.pop_front();
               if (rsp_bus.result_value !== want.value || rsp_bus.result_column !== want.column
                   || rsp_bus.last_column !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"result %0d mismatch: expected value %h column %0d last %0b,",
                               " got value %h column %0d last %0b"}, checked, want.value,
                              want.column, want.last, rsp_bus.result_value,
                              rsp_bus.result_column, rsp_bus.last_column);
               end
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_POINTS_IN_USE:  points_reg = csr_bus.data[POINTS_W-1:0];
               CSR_COLUMNS_IN_USE: columns_reg = csr_bus.data[COLUMNS_W-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            case (req_bus.opcode)
               OP_WR_BREAKPOINT: begin
                  if (int'(req_bus.point_index) < MAX_POINTS)
                     knot_table[req_bus.point_index] = req_bus.value;
               end
               OP_WR_SAMPLE: begin
                  if (int'(req_bus.point_index) < MAX_POINTS
                      && int'(req_bus.column_index) < MAX_COLUMNS)
                     sample_table[req_bus.point_index][req_bus.column_index] = req_bus.value;
               end
               OP_QUERY: interpolate_query(req_bus.value);
               default: ;
            endcase
         end
      end
      fail_count      <= mismatches;
      outstanding     <= expected_columns.size();
      results_checked <= checked;
   end

endmodule

// ===== tb/tb_table_linear_interpolator.sv =====
`timescale 1ns / 100ps
// testbench top of the table linear interpolator: clock, reset, table loads, queries,
// register settings, random idling and the verdict
// depends on tli_pkg, tli_if, tli_checker and the rtl of the block
module tb_table_linear_interpolator;
   import tli_pkg::*;

   localparam int MAX_POINTS   = 256;
   localparam int MAX_COLUMNS  = 4;
   localparam int IDLE_PERCENT = 27;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam int STALL_LIMIT  = 3000;
   localparam int PHASES       = 8;

   localparam logic [OPCODE_W-1:0]  OP_IGNORED   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   localparam logic [CSR_DATA_W-1:0] PHASE_POINTS [PHASES] =
      '{9'd1, 9'd0, 9'd8, 9'd5, 9'd4, 9'd3, 9'd6, 9'd2};
   localparam logic [CSR_DATA_W-1:0] PHASE_COLUMNS [PHASES] =
      '{9'd2, 9'h1f8, 9'd1, 9'h007, 9'd3, 9'h101, 9'd2, 9'd1};
   localparam int PHASE_ITEMS [PHASES] = '{5, 4, 20, 12, 6, 4, 5, 4};

   localparam logic signed [DATA_W-1:0] CORNER_KNOTS [3] =
      '{32'sh8000_0000, -32'sd65536, 32'sh7fff_ffff};
   localparam logic signed [DATA_W-1:0] CORNER_SAMPLES [3][4] = '{
      '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1},
      '{32'sd65536, -32'sd65536, 32'sh1234_5678, 32'sh0001_8000},
      '{32'sh7fff_ffff, 32'sh8000_0000, -32'sd1, 32'sd0}};
   localparam logic signed [DATA_W-1:0] CORNER_QUERIES [7] =
      '{32'sh8000_0000, 32'sh7fff_ffff, -32'sd65536, -32'sd65537, -32'sd65535, 32'sd0,
        32'sh7fff_fffe};

   logic clock;
   logic reset;
   logic steady;
   int   holds_asked;
   int   fail_count;
   int   outstanding;
   int   results_checked;
   int   stall_cycles = 0;
   int   query_count = 0;
   int   write_count = 0;
   int   ignored_count = 0;
   int   setting_count = 0;
   int   points_eff;
   int   columns_eff;
   logic signed [DATA_W-1:0] knots [$];

   tli_req_if req_bus ();
   tli_rsp_if rsp_bus ();
   tli_csr_if csr_bus ();

   table_linear_interpolator #(
      .MAX_POINTS (MAX_POINTS),
      .MAX_COLUMNS(MAX_COLUMNS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   tli_checker #(
      .MAX_POINTS (MAX_POINTS),
      .MAX_COLUMNS(MAX_COLUMNS)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_bus        (csr_bus),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .results_checked(results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("no beat on any channel for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // result side: random back-pressure, plus one long hold-off on request
   initial begin : result_side
      int holds_done;
      holds_done    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_asked > holds_done) begin
            holds_done++;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   task automatic offer_item(input logic [OPCODE_W-1:0]   op,
                             input logic [ROW_IDX_W-1:0]  row,
                             input logic [COL_IDX_W-1:0]  col,
                             input logic signed [DATA_W-1:0] val);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= op;
      req_bus.point_index  <= row;
      req_bus.column_index <= col;
      req_bus.value        <= val;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      case (op)
         OP_QUERY:   query_count++;
         OP_IGNORED: ignored_count++;
         default:    write_count++;
      endcase
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0]  idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
   endtask

   // wait until every expected result is in and the block has gone quiet
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic apply_setting(input logic [CSR_DATA_W-1:0] points_data,
                                input logic [CSR_DATA_W-1:0] columns_data,
                                input logic                  touch_unmapped);
      settle();
      if (touch_unmapped) write_register(CSR_UNMAPPED, CSR_DATA_W'($urandom));
      write_register(CSR_POINTS_IN_USE, points_data);
      write_register(CSR_COLUMNS_IN_USE, columns_data);
      csr_bus.valid <= 1'b0;
      points_eff  = int'(points_data);
      if (points_eff < 1) points_eff = 1;
      if (points_eff > MAX_POINTS) points_eff = MAX_POINTS;
      columns_eff = int'(columns_data[COLUMNS_W-1:0]);
      if (columns_eff < 1) columns_eff = 1;
      if (columns_eff > MAX_COLUMNS) columns_eff = MAX_COLUMNS;
      setting_count++;
   endtask

   function automatic logic signed [DATA_W-1:0] random_sample();
      case ($urandom_range(7))
         0:       return 32'sh7fff_ffff;
         1:       return 32'sh8000_0000;
         2:       return DATA_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
         default: return $urandom;
      endcase
   endfunction

   // loads ascending breakpoints, either spread over the whole range or closely stepped, and samples
   task automatic load_tables();
      longint                   spacing;
      logic signed [DATA_W-1:0] base;
      int                       step_max;
      knots.delete();
      if ($urandom_range(1)) begin
         spacing = (longint'(1) << DATA_W) / points_eff;
         for (int i = 0; i < points_eff; i++)
            knots.push_back(DATA_W'(-(longint'(1) << (DATA_W - 1)) + i * spacing
                                    + longint'($urandom) % spacing));
      end else begin
         base     = DATA_W'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
         step_max = 1 << $urandom_range(4, 18);
         for (int i = 0; i < points_eff; i++) begin
            knots.push_back(base);
            base = base + DATA_W'($urandom_range(1, step_max));
         end
      end
      for (int i = 0; i < points_eff; i++)
         offer_item(OP_WR_BREAKPOINT, ROW_IDX_W'(i), COL_IDX_W'($urandom), knots[i]);
      for (int i = 0; i < points_eff; i++)
         for (int c = 0; c < columns_eff; c++)
            offer_item(OP_WR_SAMPLE, ROW_IDX_W'(i), COL_IDX_W'(c), random_sample());
   endtask

   function automatic logic signed [DATA_W-1:0] pick_abscissa();
      int     seg;
      longint gap;
      case ($urandom_range(9))
         0: return $urandom;
         1: return knots[0] - $urandom_range(0, 100);
         2: return knots[$] + $urandom_range(0, 100);
         3: return knots[$urandom_range(0, knots.size() - 1)];
         default: begin
            if (knots.size() < 2) return $urandom;
            seg = $urandom_range(0, knots.size() - 2);
            gap = longint'(knots[seg+1]) - longint'(knots[seg]);
            if (gap <= 0) return knots[seg];
            return DATA_W'(longint'(knots[seg]) + longint'($urandom) % gap);
         end
      endcase
   endfunction

   // returns 1 for an item the block acts on, 0 for an ignored one
   task automatic random_item(output int counted);
      int                       pick;
      int                       row;
      logic signed [DATA_W-1:0] val;
      pick    = $urandom_range(99);
      counted = 1;
      if (pick < 60) begin
         offer_item(OP_QUERY, ROW_IDX_W'($urandom), COL_IDX_W'($urandom), pick_abscissa());
      end else if (pick < 72) begin
         offer_item(OP_WR_SAMPLE, ROW_IDX_W'($urandom_range(0, points_eff - 1)),
                    COL_IDX_W'($urandom_range(0, columns_eff - 1)), random_sample());
      end else if (pick < 80) begin
         offer_item(OP_WR_SAMPLE, ROW_IDX_W'($urandom), COL_IDX_W'($urandom), random_sample());
      end else if (pick < 94) begin
         // breakpoint rewrite, may leave the table out of order
         row = (pick < 88) ? $urandom_range(0, points_eff - 1) : $urandom_range(0, 255);
         val = random_sample();
         if (row < knots.size()) knots[row] = val;
         offer_item(OP_WR_BREAKPOINT, ROW_IDX_W'(row), COL_IDX_W'($urandom), val);
      end else begin
         counted = 0;
         offer_item(OP_IGNORED, ROW_IDX_W'($urandom), COL_IDX_W'($urandom), $urandom);
      end
   endtask

   initial begin : stimulus
      int done;
      int counted;
      reset                = 1'b1;
      steady               = 1'b0;
      holds_asked          = 0;
      req_bus.valid        = 1'b0;
      req_bus.opcode       = OP_WR_BREAKPOINT;
      req_bus.point_index  = '0;
      req_bus.column_index = '0;
      req_bus.value        = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = CSR_POINTS_IN_USE;
      csr_bus.data         = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // corner table: extreme breakpoints and samples, every column
      apply_setting(9'd3, 9'd4, 1'b0);
      knots.delete();
      for (int i = 0; i < 3; i++) begin
         knots.push_back(CORNER_KNOTS[i]);
         offer_item(OP_WR_BREAKPOINT, ROW_IDX_W'(i), '0, CORNER_KNOTS[i]);
      end
      for (int i = 0; i < 3; i++)
         for (int c = 0; c < 4; c++)
            offer_item(OP_WR_SAMPLE, ROW_IDX_W'(i), COL_IDX_W'(c), CORNER_SAMPLES[i][c]);
      for (int i = 0; i < 7; i++)
         offer_item(OP_QUERY, '0, '0, CORNER_QUERIES[i]);
      offer_item(OP_IGNORED, '1, '1, '1);

      for (int p = 0; p < PHASES; p++) begin
         apply_setting(PHASE_POINTS[p], PHASE_COLUMNS[p], p == PHASES - 1);
         load_tables();
         if (p == 2) holds_asked <= holds_asked + 1;
         if (p == 3) steady <= 1'b1;
         done = 0;
         while (done < PHASE_ITEMS[p]) begin
            random_item(counted);
            done += counted;
         end
         if (p == 3) steady <= 1'b0;
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d queries, %0d table writes and %0d ignored items over %0d settings",
               query_count, write_count, ignored_count, setting_count);
      $display("%0d column results compared, %0d failures", results_checked, fail_count);
      if (outstanding != 0) $display("%0d expected results never arrived", outstanding);
      if (fail_count == 0 && outstanding == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tli_pkg.sv
rtl/tli_if.sv
rtl/tli_ram.sv
rtl/tli_div.sv
rtl/table_linear_interpolator.sv
rtl/tli_chk.sv
tb/tli_checker.sv
tb/tb_table_linear_interpolator.sv
